@@ hdl/amcc_pkg.sv @@
// Shared types, sizes and codes of the adjacency matrix complete check block.
`default_nettype none

package amcc_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int COUNT_BITS   = 8;
    localparam int LABEL_W      = 8;
    localparam int VC_W         = 5;
    localparam int IDX_W        = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int NUM_W        = (CNT_W > VC_W) ? CNT_W : VC_W;

    localparam logic [VC_W-1:0]       VC_RESET  = 5'd16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [LABEL_W-1:0] t_label;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_EDGE  = 2'd1,
        CMD_CHECK = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd   cmd;
        t_label label_a;
        t_label label_b;
    } t_in_word;

    typedef struct packed {
        t_status status;
        logic    is_complete;
    } t_out_word;

    typedef struct packed {
        logic   valid;
        logic   is_check;
        t_label label_a;
        t_label label_b;
        logic   found_a;
        t_idx   idx_a;
        logic   found_b;
        t_idx   idx_b;
        logic   ok;
    } t_token;

    typedef struct packed {
        logic             clear;
        logic             load;
        t_idx             load_idx;
        t_label           load_label;
        logic             bump;
        t_idx             bump_a;
        t_idx             bump_b;
        logic [CNT_W-1:0] loaded;
        logic [NUM_W-1:0] span;
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ hdl/amcc_cell.sv @@
// One vertex cell: label, matrix row, label match and row check on the passing token.
`default_nettype none

module amcc_cell
    import amcc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_idx      i_index,
    input  wire t_cell_ctl i_ctl,
    input  wire t_token    i_tok,
    output t_token         o_tok
);

    t_label                r_label;
    logic [COUNT_BITS-1:0] r_row [MAX_VERTICES];
    logic [COUNT_BITS-1:0] n_row [MAX_VERTICES];
    t_token                r_tok;
    t_token                n_tok;

    logic label_live;
    logic row_active;
    logic row_ok;

    assign label_live = CNT_W'(i_index) < i_ctl.loaded;
    assign row_active = NUM_W'(i_index) < i_ctl.span;

    always_comb begin
        logic [1:0]            inc;
        logic [COUNT_BITS:0]   sum;
        row_ok = 1'b1;
        for (int j = 0; j < MAX_VERTICES; j++) begin
            if (NUM_W'(j) < i_ctl.span) begin
                if (t_idx'(j) == i_index) begin
                    if (r_row[j] != '0) row_ok = 1'b0;
                end else begin
                    if (r_row[j] != COUNT_BITS'(1)) row_ok = 1'b0;
                end
            end
            inc = 2'd0;
            if (i_ctl.bump && i_index == i_ctl.bump_a && t_idx'(j) == i_ctl.bump_b) begin
                inc = inc + 2'd1;
            end
            if (i_ctl.bump && i_index == i_ctl.bump_b && t_idx'(j) == i_ctl.bump_a) begin
                inc = inc + 2'd1;
            end
            sum = {1'b0, r_row[j]} + (COUNT_BITS + 1)'(inc);
            if (sum > {1'b0, COUNT_MAX}) begin
                n_row[j] = COUNT_MAX;
            end else begin
                n_row[j] = sum[COUNT_BITS-1:0];
            end
        end
    end

    always_comb begin
        n_tok = i_tok;
        if (label_live && r_label == i_tok.label_a) begin
            n_tok.found_a = 1'b1;
            n_tok.idx_a   = i_index;
        end
        if (label_live && r_label == i_tok.label_b) begin
            n_tok.found_b = 1'b1;
            n_tok.idx_b   = i_index;
        end
        n_tok.ok = i_tok.ok & (!row_active | row_ok);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && i_ctl.load_idx == i_index) begin
            r_label <= i_ctl.load_label;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            for (int j = 0; j < MAX_VERTICES; j++) begin
                r_row[j] <= '0;
            end
        end else begin
            for (int j = 0; j < MAX_VERTICES; j++) begin
                r_row[j] <= n_row[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= i_tok.valid;
        end
        r_tok.is_check <= n_tok.is_check;
        r_tok.label_a  <= n_tok.label_a;
        r_tok.label_b  <= n_tok.label_b;
        r_tok.found_a  <= n_tok.found_a;
        r_tok.idx_a    <= n_tok.idx_a;
        r_tok.found_b  <= n_tok.found_b;
        r_tok.idx_b    <= n_tok.idx_b;
        r_tok.ok       <= n_tok.ok;
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

@@ hdl/adjacency_matrix_complete_check_top.sv @@
// Top level: command control, result register and the row of vertex cells.
//
//   channel | direction | handshake               | word
//   in      | input     | i_in_valid / o_in_ready | t_in_word (cmd, label_a, label_b)
//   out     | output    | o_out_valid/i_out_ready | t_out_word (status, is_complete)
//   cfg     | input     | i_cfg_valid/o_cfg_ready | vertex_count, 5 bits
//
// For load and clear the result is registered at the accept edge.
// Edge and check send a token down the MAX_VERTICES cells, one cell a cycle; at
// the tail an edge whose labels are both found bumps both matrix cells at once.
// A new word is taken only while no command is in the cells and the result
// register is free or being emptied. Reset clears the matrix and the label count,
// sets vertex_count to 16; cfg is always ready.
`default_nettype none

module adjacency_matrix_complete_check_top
    import amcc_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire t_in_word        i_in_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output t_out_word            o_out_data,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [VC_W-1:0] i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HOLD
    } t_state;

    t_state           r_state;
    logic [VC_W-1:0]  r_vcount;
    logic [CNT_W-1:0] r_loaded;
    logic             r_out_valid;
    t_out_word        r_out;
    t_out_word        r_pend;

    t_token    w_tok [MAX_VERTICES + 1];
    t_token    tail;
    t_cell_ctl ctl;
    t_out_word fin;

    logic             out_free;
    logic             out_load;
    logic             accept;
    logic             table_full;
    logic [NUM_W-1:0] vc_ext;
    logic [NUM_W-1:0] max_ext;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && out_free;
    assign accept      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign table_full  = r_loaded >= CNT_W'(MAX_VERTICES);
    assign vc_ext      = NUM_W'(r_vcount);
    assign max_ext     = NUM_W'(MAX_VERTICES);
    assign tail        = w_tok[MAX_VERTICES];
    assign out_load    = (accept &&
                          (i_in_data.cmd == CMD_LOAD || i_in_data.cmd == CMD_CLEAR)) ||
                         ((r_state == S_SCAN) && tail.valid && out_free) ||
                         ((r_state == S_HOLD) && out_free);

    always_comb begin
        w_tok[0]          = '0;
        w_tok[0].valid    = accept &&
                            (i_in_data.cmd == CMD_EDGE || i_in_data.cmd == CMD_CHECK);
        w_tok[0].is_check = i_in_data.cmd == CMD_CHECK;
        w_tok[0].label_a  = i_in_data.label_a;
        w_tok[0].label_b  = i_in_data.label_b;
        w_tok[0].ok       = 1'b1;
    end

    always_comb begin
        ctl            = '0;
        ctl.clear      = accept && i_in_data.cmd == CMD_CLEAR;
        ctl.load       = accept && i_in_data.cmd == CMD_LOAD && !table_full;
        ctl.load_idx   = r_loaded[IDX_W-1:0];
        ctl.load_label = i_in_data.label_a;
        ctl.bump       = (r_state == S_SCAN) && tail.valid && !tail.is_check &&
                         tail.found_a && tail.found_b;
        ctl.bump_a     = tail.idx_a;
        ctl.bump_b     = tail.idx_b;
        ctl.loaded     = r_loaded;
        ctl.span       = (vc_ext > max_ext) ? max_ext : vc_ext;
    end

    always_comb begin
        fin = '0;
        if (tail.is_check) begin
            fin.status      = ST_OK;
            fin.is_complete = tail.ok;
        end else if (tail.found_a && tail.found_b) begin
            fin.status = ST_OK;
        end else begin
            fin.status = ST_MISS;
        end
    end

    for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
        amcc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (t_idx'(k)),
            .i_ctl   (ctl),
            .i_tok   (w_tok[k]),
            .o_tok   (w_tok[k + 1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vcount    <= VC_RESET;
            r_loaded    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_vcount <= i_cfg_data;
            end
            r_out_valid <= out_load || (r_out_valid && !i_out_ready);
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (i_in_data.cmd)
                            CMD_LOAD: begin
                                if (table_full) begin
                                    r_out <= '{status: ST_FULL, is_complete: 1'b0};
                                end else begin
                                    r_out    <= '{status: ST_OK, is_complete: 1'b0};
                                    r_loaded <= r_loaded + CNT_W'(1);
                                end
                            end
                            CMD_CLEAR: begin
                                r_out    <= '0;
                                r_loaded <= '0;
                            end
                            CMD_EDGE, CMD_CHECK: begin
                                r_state <= S_SCAN;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (tail.valid) begin
                        if (out_free) begin
                            r_out   <= fin;
                            r_state <= S_IDLE;
                        end else begin
                            r_pend  <= fin;
                            r_state <= S_HOLD;
                        end
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_out   <= r_pend;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
